@@ rtl/atsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package atsc_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] weight;
    logic [5:0]  column;
    logic [15:0] fraction;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] sampled_index;
  } rsp_t;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_BUILD  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;
  localparam logic [1:0] OP_BAD    = 2'd3;

  localparam logic [2:0] ST_LOADED = 3'd0;
  localparam logic [2:0] ST_BUILT  = 3'd1;
  localparam logic [2:0] ST_SAMPLE = 3'd2;
  localparam logic [2:0] ST_ERROR  = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] weight;
    logic [5:0]  column;
    logic [15:0] fraction;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic take;
  } cmd_hs_t;

endpackage

`default_nettype wire

@@ rtl/alias_table_sampler_core.sv @@
// Loads and errors go straight to DONE; samples pass SRD, SMUL and SCMP first.
// Build sorts entries (CRD, CMUL, CPUSH), then pairs columns (PCHK, PRD/FRD, PEXE/FEXE).
// One request is worked at a time in the execution unit; a 4-entry queue takes new ones.
// Synchronous reset empties the queue, clears count, total and the built flag.
// The weight, threshold and index memories are not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none

module alias_table_sampler_core #(
  parameter int MAX_ENTRIES   = 64,
  parameter int WEIGHT_BITS   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_stall,
  input  atsc_pkg::req_t req,
  output logic           rsp_valid,
  input  wire            rsp_stall,
  output atsc_pkg::rsp_t rsp
);

  atsc_pkg::cmd_t    cmd;
  atsc_pkg::cmd_hs_t hs;
  logic              cmd_valid;
  logic              cmd_take;

  assign hs.valid = cmd_valid;
  assign hs.take = cmd_take;

  atsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (hs.take)
  );

  atsc_back #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .WEIGHT_BITS   (WEIGHT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .hs_in     (hs),
    .cmd_take  (cmd_take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

@@ rtl/atsc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module atsc_front (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_stall,
  input  atsc_pkg::req_t req,
  output atsc_pkg::cmd_t cmd,
  output logic           cmd_valid,
  input  wire            cmd_take
);

  localparam int PW = $clog2(atsc_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(atsc_pkg::QUEUE_DEPTH + 1);

  atsc_pkg::cmd_t q_mem [atsc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  head;
  logic [PW-1:0]  tail;
  logic [CW-1:0]  cnt;
  atsc_pkg::cmd_t classified;
  logic           push;
  logic           pop;

  always_comb begin
    classified = '0;
    classified.weight = req.weight;
    classified.column = req.column;
    classified.fraction = req.fraction;
    case (req.req_type)
      atsc_pkg::OP_LOAD:   classified.op = atsc_pkg::OP_LOAD;
      atsc_pkg::OP_BUILD:  classified.op = atsc_pkg::OP_BUILD;
      atsc_pkg::OP_SAMPLE: classified.op = atsc_pkg::OP_SAMPLE;
      default:             classified.op = atsc_pkg::OP_BAD;
    endcase
  end

  assign req_stall = (cnt == CW'(atsc_pkg::QUEUE_DEPTH));
  assign push = req_valid && !req_stall;
  assign cmd_valid = (cnt != '0);
  assign pop = cmd_valid && cmd_take;
  assign cmd = q_mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[tail] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        tail <= tail + PW'(1);
      end
      if (pop) begin
        head <= head + PW'(1);
      end
      cnt <= cnt + CW'(push) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/atsc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module atsc_back #(
  parameter int MAX_ENTRIES   = 64,
  parameter int WEIGHT_BITS   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  atsc_pkg::cmd_t    cmd,
  input  atsc_pkg::cmd_hs_t hs_in,
  output logic              cmd_take,
  output logic              rsp_valid,
  input  wire               rsp_stall,
  output atsc_pkg::rsp_t    rsp
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = WEIGHT_BITS + CW;
  localparam int FW = SW + IW;
  localparam int TW = SW + 2 * IW;
  localparam int PW = FRACTION_BITS + SW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRD   = 4'd1;
  localparam logic [3:0] S_SMUL  = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_CRD   = 4'd4;
  localparam logic [3:0] S_CMUL  = 4'd5;
  localparam logic [3:0] S_CPUSH = 4'd6;
  localparam logic [3:0] S_PCHK  = 4'd7;
  localparam logic [3:0] S_PRD   = 4'd8;
  localparam logic [3:0] S_PEXE  = 4'd9;
  localparam logic [3:0] S_FRD   = 4'd10;
  localparam logic [3:0] S_FEXE  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]               state;
  logic [CW-1:0]            count;
  logic [SW-1:0]            total;
  logic                     ready;
  logic [WEIGHT_BITS-1:0]   w_mem [MAX_ENTRIES];
  logic [WEIGHT_BITS-1:0]   w_rd;
  logic [FW-1:0]            s_mem [MAX_ENTRIES];
  logic [FW-1:0]            l_mem [MAX_ENTRIES];
  logic [FW-1:0]            s_rd;
  logic [FW-1:0]            l_rd;
  logic [IW-1:0]            s_head;
  logic [IW-1:0]            s_tail;
  logic [CW-1:0]            s_cnt;
  logic [IW-1:0]            l_head;
  logic [IW-1:0]            l_tail;
  logic [CW-1:0]            l_cnt;
  logic [TW-1:0]            tab_mem [MAX_ENTRIES];
  logic [TW-1:0]            tab_rd;
  logic [CW-1:0]            cls_i;
  logic [CW-1:0]            col;
  logic [SW-1:0]            scaled;
  logic [IW-1:0]            cur_ix;
  logic [FRACTION_BITS-1:0] cur_frac;
  logic [PW-1:0]            prod;
  atsc_pkg::rsp_t           res;
  logic                     fifo_clear;

  logic                     s_push;
  logic                     s_pop;
  logic                     l_push;
  logic                     l_pop;
  logic [FW-1:0]            push_data;
  logic                     tab_we;
  logic [TW-1:0]            tab_wdata;
  logic                     w_we;
  logic [IW-1:0]            w_waddr;
  logic [WEIGHT_BITS-1:0]   wv;
  logic [CW-1:0]            cnt_eff;
  logic [SW-1:0]            tot_eff;
  logic [SW-1:0]            sv;
  logic [SW-1:0]            lv;
  logic [SW-1:0]            nw;
  logic [IW-1:0]            si;
  logic [IW-1:0]            li;
  logic [IW-1:0]            fix;
  logic [SW-1:0]            thr;
  logic                     take_own;

  assign cmd_take = (state == S_IDLE);
  assign wv = WEIGHT_BITS'(cmd.weight);
  assign cnt_eff = ready ? '0 : count;
  assign tot_eff = ready ? '0 : total;
  assign sv = s_rd[FW-1:IW];
  assign si = s_rd[IW-1:0];
  assign lv = l_rd[FW-1:IW];
  assign li = l_rd[IW-1:0];
  assign nw = lv - total + sv;
  assign thr = tab_rd[TW-1:2*IW];
  assign take_own = (prod < {thr, {FRACTION_BITS{1'b0}}});

  always_comb begin
    s_push = 1'b0;
    s_pop = 1'b0;
    l_push = 1'b0;
    l_pop = 1'b0;
    push_data = '0;
    tab_we = 1'b0;
    tab_wdata = '0;
    w_we = 1'b0;
    w_waddr = IW'(cnt_eff);
    fix = IW'(col);
    case (state)
      S_IDLE: begin
        w_we = hs_in.valid && (cmd.op == atsc_pkg::OP_LOAD) &&
               (cnt_eff < CW'(MAX_ENTRIES));
      end
      S_CPUSH: begin
        push_data = {scaled, IW'(cls_i)};
        if (scaled > total) begin
          l_push = 1'b1;
        end else begin
          s_push = 1'b1;
        end
      end
      S_PEXE: begin
        tab_we = 1'b1;
        s_pop = 1'b1;
        if (l_cnt == '0) begin
          tab_wdata = {total, si, si};
        end else begin
          tab_wdata = {sv, si, li};
          l_pop = 1'b1;
          push_data = {nw, li};
          if (nw < total) begin
            s_push = 1'b1;
          end else begin
            l_push = 1'b1;
          end
        end
      end
      S_FEXE: begin
        tab_we = 1'b1;
        if (l_cnt != '0) begin
          fix = li;
          l_pop = 1'b1;
        end else if (s_cnt != '0) begin
          fix = si;
          s_pop = 1'b1;
        end
        tab_wdata = {total, fix, fix};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_waddr] <= wv;
    end
    w_rd <= w_mem[IW'(cls_i)];
  end

  always_ff @(posedge clk) begin
    if (s_push) begin
      s_mem[s_tail] <= push_data;
    end
    s_rd <= s_mem[s_head];
  end

  always_ff @(posedge clk) begin
    if (l_push) begin
      l_mem[l_tail] <= push_data;
    end
    l_rd <= l_mem[l_head];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[IW'(col)] <= tab_wdata;
    end
    tab_rd <= tab_mem[cur_ix];
  end

  assign fifo_clear = (state == S_IDLE) && hs_in.valid && (cmd.op == atsc_pkg::OP_BUILD);

  always_ff @(posedge clk) begin
    if (rst || fifo_clear) begin
      s_head <= '0;
      s_tail <= '0;
      s_cnt <= '0;
      l_head <= '0;
      l_tail <= '0;
      l_cnt <= '0;
    end else begin
      if (s_push) begin
        s_tail <= (s_tail == IW'(MAX_ENTRIES - 1)) ? '0 : s_tail + IW'(1);
      end
      if (s_pop) begin
        s_head <= (s_head == IW'(MAX_ENTRIES - 1)) ? '0 : s_head + IW'(1);
      end
      if (l_push) begin
        l_tail <= (l_tail == IW'(MAX_ENTRIES - 1)) ? '0 : l_tail + IW'(1);
      end
      if (l_pop) begin
        l_head <= (l_head == IW'(MAX_ENTRIES - 1)) ? '0 : l_head + IW'(1);
      end
      s_cnt <= s_cnt + CW'(s_push) - CW'(s_pop);
      l_cnt <= l_cnt + CW'(l_push) - CW'(l_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      ready <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (hs_in.valid) begin
            res.sampled_index <= 6'd0;
            state <= S_DONE;
            case (cmd.op)
              atsc_pkg::OP_LOAD: begin
                ready <= 1'b0;
                if (cnt_eff >= CW'(MAX_ENTRIES)) begin
                  res.status <= atsc_pkg::ST_FULL;
                  count <= cnt_eff;
                  total <= tot_eff;
                end else begin
                  res.status <= atsc_pkg::ST_LOADED;
                  count <= cnt_eff + CW'(1);
                  total <= tot_eff + SW'(wv);
                end
              end
              atsc_pkg::OP_BUILD: begin
                res.status <= atsc_pkg::ST_ERROR;
                if (count == '0 || total == '0) begin
                  ready <= 1'b0;
                end else begin
                  cls_i <= '0;
                  col <= '0;
                  state <= S_CRD;
                end
              end
              atsc_pkg::OP_SAMPLE: begin
                res.status <= atsc_pkg::ST_ERROR;
                if (ready && ({{CW{1'b0}}, cmd.column} < {6'd0, count})) begin
                  cur_ix <= IW'(cmd.column);
                  cur_frac <= FRACTION_BITS'(cmd.fraction);
                  state <= S_SRD;
                end
              end
              default: begin
                res.status <= atsc_pkg::ST_ERROR;
              end
            endcase
          end
        end
        S_SRD: begin
          state <= S_SMUL;
        end
        S_SMUL: begin
          prod <= PW'(cur_frac) * PW'(total);
          state <= S_SCMP;
        end
        S_SCMP: begin
          res.status <= atsc_pkg::ST_SAMPLE;
          res.sampled_index <= take_own ? 6'(tab_rd[2*IW-1:IW]) : 6'(tab_rd[IW-1:0]);
          state <= S_DONE;
        end
        S_CRD: begin
          state <= S_CMUL;
        end
        S_CMUL: begin
          scaled <= SW'(w_rd) * SW'(count);
          state <= S_CPUSH;
        end
        S_CPUSH: begin
          cls_i <= cls_i + CW'(1);
          state <= (cls_i + CW'(1) == count) ? S_PCHK : S_CRD;
        end
        S_PCHK: begin
          if ((({1'b0, col} + (CW + 1)'(1)) < {1'b0, count}) && (s_cnt != '0)) begin
            state <= S_PRD;
          end else if (col < count) begin
            state <= S_FRD;
          end else begin
            ready <= 1'b1;
            res.status <= atsc_pkg::ST_BUILT;
            state <= S_DONE;
          end
        end
        S_PRD: begin
          state <= S_PEXE;
        end
        S_PEXE: begin
          col <= col + CW'(1);
          state <= S_PCHK;
        end
        S_FRD: begin
          state <= S_FEXE;
        end
        S_FEXE: begin
          col <= col + CW'(1);
          state <= S_PCHK;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp <= res;
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
